// ===== hw/rtl/mtse_pkg.sv =====
// Package for the multitouch slot event generator: sizes, fixed-point widths,
// event and register codes. No dependencies; every other file imports it.
`default_nettype none

package mtse_pkg;

  // Slot table and coordinate scaling
  localparam int SLOT_COUNT = 10;
  localparam int COORD_MAX  = 32767;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths
  localparam int SLOT_ID_W  = 8;
  localparam int ID_W       = 16;
  localparam int VAL_W      = 17;
  localparam int POS_W      = 15;
  localparam int LEN_W      = 15;
  localparam int ORG_W      = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed-point mapping: 16 fractional bits, positions normalised to 32767
  localparam int FRAC       = 16;
  localparam int NORM_DIV   = 32767;
  localparam int PROD1_W    = POS_W + LEN_W;          // pos * target length
  localparam int DIV_W      = PROD1_W + FRAC;         // shared divider dividend
  localparam int Q1_W       = LEN_W + FRAC;           // scaled target offset
  localparam int ODIFF_W    = ORG_W + 1;              // target org - desktop org
  localparam int G_W        = ODIFF_W + FRAC + 2;     // signed desktop offset
  localparam int MAG_W      = G_W - 1;                // its magnitude
  localparam int CMAX_W     = 16;
  localparam int SCALED_W   = MAG_W + CMAX_W;
  localparam int DVD2_W     = SCALED_W - FRAC;        // second dividend, integer part
  localparam int CNT_W      = $clog2(DIV_W + 1);

  // Saturation limits of the signed event value
  localparam int SAT_POS     = 2 ** (VAL_W - 1) - 1;
  localparam int SAT_NEG_MAG = 2 ** (VAL_W - 1);

  typedef enum logic [KIND_W-1:0] {
    EV_SLOT  = 3'd0,
    EV_TRACK = 3'd1,
    EV_POS_X = 3'd2,
    EV_POS_Y = 3'd3,
    EV_SYNC  = 3'd4
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LEFT    = 3'd0,
    REG_TARGET_TOP     = 3'd1,
    REG_TARGET_WIDTH   = 3'd2,
    REG_TARGET_HEIGHT  = 3'd3,
    REG_DESKTOP_LEFT   = 3'd4,
    REG_DESKTOP_TOP    = 3'd5,
    REG_DESKTOP_WIDTH  = 3'd6,
    REG_DESKTOP_HEIGHT = 3'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/mtse_if.sv =====
// Channel interfaces of the multitouch slot event generator: finger reports,
// events and configuration writes. Depends on mtse_pkg.
`default_nettype none

interface mtse_in_if;
  import mtse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SLOT_ID_W-1:0] slot_id;
  logic                 finger_down;
  logic [POS_W-1:0]     x_position;
  logic [POS_W-1:0]     y_position;
  logic                 frame_end;

  modport source (output valid, slot_id, finger_down, x_position, y_position, frame_end,
                  input ready);
  modport sink   (input valid, slot_id, finger_down, x_position, y_position, frame_end,
                  output ready);
endinterface

interface mtse_out_if;
  import mtse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       event_kind;
  logic signed [VAL_W-1:0] event_value;
  logic                    last_of_run;

  modport source (output valid, event_kind, event_value, last_of_run, input ready);
  modport sink   (input valid, event_kind, event_value, last_of_run, output ready);
endinterface

interface mtse_cfg_if;
  import mtse_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/multitouch_slot_event_generator_top.sv =====
// Multitouch slot event generator: one finger report in, up to five events out
// (slot, tracking id, x, y, sync), each transaction on a valid/ready channel. A report
// is taken only while the block is idle. With mapping on, each axis runs twice
// through one bit-serial restoring divider (46 then 34 quotient bits, one per cycle).
// Events then leave through a single output register, and a new report is taken while
// the last event still waits there.
// Depends on mtse_pkg and the interfaces in mtse_if.sv.
`default_nettype none

module multitouch_slot_event_generator_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  mtse_in_if.sink     in_i,
  mtse_out_if.source  out_o,
  mtse_cfg_if.sink    cfg_i
);
  import mtse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_DIV1, ST_CLAMP, ST_ABS, ST_SCALE, ST_DIV2, ST_FIN,
    ST_SLOT, ST_ID, ST_X, ST_Y, ST_SYNC
  } state_e;

  // Configuration registers
  logic signed [ORG_W-1:0] tleft_q, ttop_q, dleft_q, dtop_q;
  logic [LEN_W-1:0]        twidth_q, theight_q, dwidth_q, dheight_q;

  // Slot table: busy bit per slot, id stored while busy
  logic [SLOT_COUNT-1:0] busy_q;
  logic [ID_W-1:0]       ids_q [SLOT_COUNT];
  logic [ID_W-1:0]       next_id_q;

  // Sequencer and datapath
  state_e                state_q, state_d;
  logic [SLOT_ID_W-1:0]  slot_q, slot_d;
  logic                  down_q, down_d;
  logic                  fend_q, fend_d;
  logic [POS_W-1:0]      x_q, x_d, y_q, y_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic                  axis_q, axis_d;
  logic [VAL_W-1:0]      xres_q, xres_d, yres_q, yres_d;
  logic [ODIFF_W-1:0]    odiff_q, odiff_d;
  logic [G_W-1:0]        g_q, g_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic [LEN_W-1:0]      rem_q, rem_d;
  logic [LEN_W-1:0]      dsr_q, dsr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Output register
  logic                  ov_q, ov_d;
  event_kind_e           okind_q, okind_d;
  logic [VAL_W-1:0]      oval_q, oval_d;
  logic                  olast_q, olast_d;

  // Input side
  logic                  in_acc;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     slot_idx;

  // Per-axis selection
  logic [POS_W-1:0]      ax_pos;
  logic [ORG_W-1:0]      ax_torg, ax_dorg;
  logic [LEN_W-1:0]      ax_tlen, ax_dlen;
  logic                  map_on;

  // Divider step and mapping arithmetic
  logic [LEN_W:0]        trial, trial_sub;
  logic                  ge;
  logic [PROD1_W-1:0]    prod1;
  logic [Q1_W-1:0]       q1, hi, qc;
  logic [SCALED_W-1:0]   scaled;
  logic [DVD2_W-1:0]     q2;
  logic [VAL_W-1:0]      sat;
  logic                  out_free;

  assign in_acc   = in_i.valid && (state_q == ST_IDLE);
  assign slot_ok  = in_i.slot_id < SLOT_ID_W'(SLOT_COUNT);
  assign slot_idx = in_i.slot_id[SLOT_W-1:0];
  assign out_free = !ov_q || out_o.ready;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = ov_q;
  assign out_o.event_kind  = okind_q;
  assign out_o.event_value = oval_q;
  assign out_o.last_of_run = olast_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tleft_q   <= '0;
      ttop_q    <= '0;
      twidth_q  <= '0;
      theight_q <= '0;
      dleft_q   <= '0;
      dtop_q    <= '0;
      dwidth_q  <= '0;
      dheight_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_TARGET_LEFT:    tleft_q   <= cfg_i.data;
        REG_TARGET_TOP:     ttop_q    <= cfg_i.data;
        REG_TARGET_WIDTH:   twidth_q  <= cfg_i.data[LEN_W-1:0];
        REG_TARGET_HEIGHT:  theight_q <= cfg_i.data[LEN_W-1:0];
        REG_DESKTOP_LEFT:   dleft_q   <= cfg_i.data;
        REG_DESKTOP_TOP:    dtop_q    <= cfg_i.data;
        REG_DESKTOP_WIDTH:  dwidth_q  <= cfg_i.data[LEN_W-1:0];
        REG_DESKTOP_HEIGHT: dheight_q <= cfg_i.data[LEN_W-1:0];
      endcase
    end
  end

  // Slot occupancy and id counter, updated as the report is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      next_id_q <= '0;
    end else if (in_acc && slot_ok) begin
      if (in_i.finger_down) begin
        if (!busy_q[slot_idx]) begin
          busy_q[slot_idx] <= 1'b1;
          next_id_q        <= next_id_q + 1'b1;
        end
      end else begin
        busy_q[slot_idx] <= 1'b0;
      end
    end
  end

  // Id storage, meaningful only while the busy bit is set
  always_ff @(posedge clk_i) begin
    if (in_acc && slot_ok && in_i.finger_down && !busy_q[slot_idx]) begin
      ids_q[slot_idx] <= next_id_q;
    end
  end

  // Axis operands
  always_comb begin
    ax_pos  = axis_q ? y_q       : x_q;
    ax_torg = axis_q ? ttop_q    : tleft_q;
    ax_dorg = axis_q ? dtop_q    : dleft_q;
    ax_tlen = axis_q ? theight_q : twidth_q;
    ax_dlen = axis_q ? dheight_q : dwidth_q;
    map_on  = (twidth_q != '0) && (theight_q != '0) && (ax_dlen != '0);
  end

  // One restoring division step and the mapping arithmetic
  always_comb begin
    trial     = {rem_q, div_q[DIV_W-1]};
    trial_sub = trial - {1'b0, dsr_q};
    ge        = trial >= {1'b0, dsr_q};
    prod1     = PROD1_W'(ax_pos) * PROD1_W'(ax_tlen);
    q1        = div_q[Q1_W-1:0];
    hi        = {ax_tlen - 1'b1, {FRAC{1'b0}}};
    qc        = (q1 > hi) ? hi : q1;
    scaled    = SCALED_W'(mag_q) * SCALED_W'(COORD_MAX);
    q2        = div_q[DVD2_W-1:0];
    // Truncated quotient, signed and saturated to the event range
    if (neg_q) begin
      sat = (q2 > DVD2_W'(SAT_NEG_MAG)) ? VAL_W'(SAT_NEG_MAG) : VAL_W'(-q2[VAL_W-1:0]);
    end else begin
      sat = (q2 > DVD2_W'(SAT_POS)) ? VAL_W'(SAT_POS) : q2[VAL_W-1:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    down_d  = down_q;
    fend_d  = fend_q;
    x_d     = x_q;
    y_d     = y_q;
    id_d    = id_q;
    axis_d  = axis_q;
    xres_d  = xres_q;
    yres_d  = yres_q;
    odiff_d = odiff_q;
    g_d     = g_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    div_d   = div_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_o.ready;
    okind_d = okind_q;
    oval_d  = oval_q;
    olast_d = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          slot_d = in_i.slot_id;
          down_d = in_i.finger_down;
          fend_d = in_i.frame_end;
          x_d    = in_i.x_position;
          y_d    = in_i.y_position;
          id_d   = busy_q[slot_idx] ? ids_q[slot_idx] : next_id_q;
          axis_d = 1'b0;
          if (slot_ok) begin
            state_d = in_i.finger_down ? ST_SETUP : ST_SLOT;
          end else begin
            state_d = in_i.frame_end ? ST_SYNC : ST_IDLE;
          end
        end
      end

      // Start an axis: pass through, or load the first division
      ST_SETUP: begin
        if (map_on) begin
          div_d   = {prod1, {FRAC{1'b0}}};
          dsr_d   = LEN_W'(NORM_DIV);
          rem_d   = '0;
          cnt_d   = CNT_W'(DIV_W);
          odiff_d = {ax_torg[ORG_W-1], ax_torg} - {ax_dorg[ORG_W-1], ax_dorg};
          state_d = ST_DIV1;
        end else begin
          if (axis_q) begin
            yres_d  = {{(VAL_W-POS_W){1'b0}}, ax_pos};
            state_d = ST_SLOT;
          end else begin
            xres_d  = {{(VAL_W-POS_W){1'b0}}, ax_pos};
            axis_d  = 1'b1;
            state_d = ST_SETUP;
          end
        end
      end

      ST_DIV1, ST_DIV2: begin
        div_d = {div_q[DIV_W-2:0], ge};
        rem_d = ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = (state_q == ST_DIV1) ? ST_CLAMP : ST_FIN;
        end
      end

      // Clamp to the target and move to desktop-relative Q.16
      ST_CLAMP: begin
        g_d = {{(G_W-ODIFF_W-FRAC){odiff_q[ODIFF_W-1]}}, odiff_q, {FRAC{1'b0}}}
            + {{(G_W-Q1_W){1'b0}}, qc};
        state_d = ST_ABS;
      end

      ST_ABS: begin
        neg_d   = g_q[G_W-1];
        mag_d   = g_q[G_W-1] ? MAG_W'(-g_q) : g_q[MAG_W-1:0];
        state_d = ST_SCALE;
      end

      // Scale by the coordinate range; the 2^16 of the divisor drops as a shift
      ST_SCALE: begin
        div_d   = {scaled[SCALED_W-1:FRAC], {(DIV_W-DVD2_W){1'b0}}};
        dsr_d   = ax_dlen;
        rem_d   = '0;
        cnt_d   = CNT_W'(DVD2_W);
        state_d = ST_DIV2;
      end

      ST_FIN: begin
        if (axis_q) begin
          yres_d  = sat;
          state_d = ST_SLOT;
        end else begin
          xres_d  = sat;
          axis_d  = 1'b1;
          state_d = ST_SETUP;
        end
      end

      // Event emission, one per free output slot
      ST_SLOT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = EV_SLOT;
          oval_d  = {{(VAL_W-SLOT_ID_W){1'b0}}, slot_q};
          olast_d = 1'b0;
          state_d = ST_ID;
        end
      end

      ST_ID: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = EV_TRACK;
          oval_d  = down_q ? {{(VAL_W-ID_W){1'b0}}, id_q} : {VAL_W{1'b1}};
          olast_d = !down_q && !fend_q;
          if (down_q) begin
            state_d = ST_X;
          end else begin
            state_d = fend_q ? ST_SYNC : ST_IDLE;
          end
        end
      end

      ST_X: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = EV_POS_X;
          oval_d  = xres_q;
          olast_d = 1'b0;
          state_d = ST_Y;
        end
      end

      ST_Y: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = EV_POS_Y;
          oval_d  = yres_q;
          olast_d = !fend_q;
          state_d = fend_q ? ST_SYNC : ST_IDLE;
        end
      end

      ST_SYNC: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = EV_SYNC;
          oval_d  = '0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, datapath and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      down_q  <= 1'b0;
      fend_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      id_q    <= '0;
      axis_q  <= 1'b0;
      xres_q  <= '0;
      yres_q  <= '0;
      odiff_q <= '0;
      g_q     <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      div_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      okind_q <= EV_SLOT;
      oval_q  <= '0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      down_q  <= down_d;
      fend_q  <= fend_d;
      x_q     <= x_d;
      y_q     <= y_d;
      id_q    <= id_d;
      axis_q  <= axis_d;
      xres_q  <= xres_d;
      yres_q  <= yres_d;
      odiff_q <= odiff_d;
      g_q     <= g_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      div_q   <= div_d;
      rem_q   <= rem_d;
      dsr_q   <= dsr_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      okind_q <= okind_d;
      oval_q  <= oval_d;
      olast_q <= olast_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtse_checker.sv =====
// Port-level checks on the event stream of the multitouch slot event generator,
// bound to the top level. Depends on mtse_pkg and the top level's interfaces.
`default_nettype none

module mtse_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           out_valid_i,
  input wire                           out_ready_i,
  input wire [mtse_pkg::KIND_W-1:0]    event_kind_i,
  input wire [mtse_pkg::VAL_W-1:0]     event_value_i,
  input wire                           last_of_run_i
);
  import mtse_pkg::*;

  // A sync always closes the run of events for its report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EV_SYNC) |-> last_of_run_i)
    else $error("sync event not marked last");

  // A slot event is never marked last: a tracking id always follows it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EV_SLOT) |-> !last_of_run_i)
    else $error("slot event marked last");

  // Only slots inside the table are reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EV_SLOT) |-> event_value_i < VAL_W'(SLOT_COUNT))
    else $error("slot event outside the table");

  // A stalled event holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i)
      && $stable(event_value_i) && $stable(last_of_run_i))
    else $error("stalled event changed");

endmodule

bind multitouch_slot_event_generator_top mtse_checker u_mtse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .event_kind_i  (out_o.event_kind),
  .event_value_i (out_o.event_value),
  .last_of_run_i (out_o.last_of_run)
);

`default_nettype wire
